>>> rtl/bise_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap integer set package
// Shared constants, operation and status codes, and sequencer states for the
// bitmap integer set engine.
// ============================================================================
package bise_pkg;

    // Bitmap geometry. The word width is set through its base-two logarithm.
    localparam int unsigned WB_LOG    = 6;
    localparam int unsigned WORD_BITS = 1 << WB_LOG;
    localparam int unsigned WORDS     = 1024;
    localparam int unsigned CAP       = WORDS * WORD_BITS;
    localparam int unsigned WIDX      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned CNT_W     = $clog2(CAP + 1);

    // Field widths of the channel words.
    localparam int unsigned OP_W   = 3;
    localparam int unsigned ELEM_W = 31;
    localparam int unsigned VAL_W  = 31;
    localparam int unsigned ST_W   = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WIDX-1:0]      t_widx;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_DELETE = 3'd1,
        OP_TEST   = 3'd2,
        OP_NEXT   = 3'd3,
        OP_COUNT  = 3'd4,
        OP_EMPTY  = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_NONE    = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RMW,
        S_SRCH,
        S_CLR,
        S_RESP
    } t_state;

endpackage

>>> rtl/bise_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap integer set request channel
// Valid/ready channel that carries one request word: operation, element and
// fill flag.
// ============================================================================
interface bise_in_if;
    logic                             valid;
    logic                             ready;
    logic [bise_pkg::OP_W-1:0]        operation;
    logic [bise_pkg::ELEM_W-1:0]      element;
    logic                             fill;

    modport source (output valid, output operation, output element, output fill,
                    input ready);
    modport sink   (input valid, input operation, input element, input fill,
                    output ready);
endinterface

>>> rtl/bise_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap integer set response channel
// Valid/ready channel that carries one response word: membership flag, value,
// unbounded flag and status.
// ============================================================================
interface bise_out_if;
    logic                             valid;
    logic                             ready;
    logic                             is_member;
    logic [bise_pkg::VAL_W-1:0]       value;
    logic                             unbounded;
    logic [bise_pkg::ST_W-1:0]        status;

    modport source (output valid, output is_member, output value, output unbounded,
                    output status, input ready);
    modport sink   (input valid, input is_member, input value, input unbounded,
                    input status, output ready);
endinterface

>>> rtl/bise_word_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap word RAM
// Simple dual-port RAM with one write port and one registered read port.
// ============================================================================
module bise_word_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bitmap_integer_set_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap integer set engine
// Keeps one integer set as a word-organized bitmap plus a trailing fill bit,
// and serves add, delete, test, next-member, count, is-empty and clear.
// ============================================================================
// Sequence: add, delete and test read the addressed word, then modify it and
// write it back, then stage the response word; count, is-empty and out-of-range
// requests go straight to the response stage; a next search scans word by word
// from the start word; a clear sweeps every word through the single RAM write port.
// One request is in flight at a time; the next is accepted once the sequencer
// is idle, while the previous response word may still wait on the output.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the RAM
// one word per cycle before the first request.
module bitmap_integer_set_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bise_in_if.sink    i_in,
    bise_out_if.source o_out
);

    localparam bise_pkg::t_widx  LAST  = bise_pkg::WIDX'(bise_pkg::WORDS - 1);
    localparam bise_pkg::t_word  ALL1  = '1;

    // Index of the lowest set bit: isolate it, then encode with OR trees.
    function automatic logic [bise_pkg::WB_LOG-1:0] low_bit(input bise_pkg::t_word m);
        bise_pkg::t_word                 lsb;
        logic [bise_pkg::WB_LOG-1:0]     pos;
        bise_pkg::t_word                 sel;
        lsb = m & (~m + 1'b1);
        for (int j = 0; j < bise_pkg::WB_LOG; j++) begin
            for (int i = 0; i < bise_pkg::WORD_BITS; i++) begin
                sel[i] = ((i >> j) & 1) == 1;
            end
            pos[j] = |(lsb & sel);
        end
        return pos;
    endfunction

    bise_pkg::t_state              r_state, n_state;
    logic [bise_pkg::OP_W-1:0]     r_op, n_op;
    logic [bise_pkg::ELEM_W-1:0]   r_elem, n_elem;
    logic                          r_fill_in, n_fill_in;
    logic                          r_fill, n_fill;
    logic [bise_pkg::CNT_W-1:0]    r_count, n_count;
    bise_pkg::t_widx               r_addr, n_addr;
    logic                          r_first, n_first;

    logic                          r_res_mem, n_res_mem;
    logic [bise_pkg::VAL_W-1:0]    r_res_val, n_res_val;
    logic [bise_pkg::ST_W-1:0]     r_res_st, n_res_st;

    logic                          r_out_valid, n_out_valid;
    logic                          r_out_mem, n_out_mem;
    logic [bise_pkg::VAL_W-1:0]    r_out_val, n_out_val;
    logic                          r_out_unb, n_out_unb;
    logic [bise_pkg::ST_W-1:0]     r_out_st, n_out_st;

    logic                          ram_wr_en;
    bise_pkg::t_widx               ram_wr_addr;
    bise_pkg::t_word               ram_wr_data;
    logic                          ram_rd_en;
    bise_pkg::t_widx               ram_rd_addr;
    bise_pkg::t_word               ram_rd_data;

    logic                          slot_free;
    logic                          in_range;
    bise_pkg::t_word               bit_mask;
    logic                          had;
    bise_pkg::t_word               scan_word;
    logic [bise_pkg::ELEM_W-1:0]   past_cap;

    bise_word_ram #(
        .DEPTH (bise_pkg::WORDS),
        .WIDTH (bise_pkg::WORD_BITS),
        .AW    (bise_pkg::WIDX)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Control and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bise_pkg::S_INIT;
            r_fill      <= 1'b0;
            r_count     <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_elem    <= n_elem;
        r_fill_in <= n_fill_in;
        r_first   <= n_first;
        r_res_mem <= n_res_mem;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_out_mem <= n_out_mem;
        r_out_val <= n_out_val;
        r_out_unb <= n_out_unb;
        r_out_st  <= n_out_st;
    end

    assign slot_free    = !r_out_valid || o_out.ready;
    assign i_in.ready   = (r_state == bise_pkg::S_IDLE);
    assign in_range     = i_in.element < bise_pkg::ELEM_W'(bise_pkg::CAP);
    assign bit_mask     = bise_pkg::WORD_BITS'(1) << r_elem[bise_pkg::WB_LOG-1:0];
    assign had          = |(ram_rd_data & bit_mask);
    assign scan_word    = ram_rd_data
                        & (r_first ? (ALL1 << r_elem[bise_pkg::WB_LOG-1:0]) : ALL1);
    assign past_cap     = (r_elem > bise_pkg::ELEM_W'(bise_pkg::CAP))
                        ? r_elem : bise_pkg::ELEM_W'(bise_pkg::CAP);

    // Sequencer: next state, RAM control and response staging.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_elem      = r_elem;
        n_fill_in   = r_fill_in;
        n_fill      = r_fill;
        n_count     = r_count;
        n_addr      = r_addr;
        n_first     = r_first;
        n_res_mem   = r_res_mem;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_mem   = r_out_mem;
        n_out_val   = r_out_val;
        n_out_unb   = r_out_unb;
        n_out_st    = r_out_st;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_addr;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = i_in.element[bise_pkg::WB_LOG +: bise_pkg::WIDX];

        unique case (r_state)
            bise_pkg::S_INIT: begin
                // Clearing pass after reset.
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
                n_addr      = bise_pkg::WIDX'(r_addr + 1'b1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = bise_pkg::S_IDLE;
                end
            end

            bise_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op      = i_in.operation;
                    n_elem    = i_in.element;
                    n_fill_in = i_in.fill;
                    n_res_mem = 1'b0;
                    n_res_val = '0;
                    n_res_st  = bise_pkg::ST_OK;
                    n_state   = bise_pkg::S_RESP;
                    case (i_in.operation)
                        bise_pkg::OP_ADD, bise_pkg::OP_DELETE: begin
                            if (in_range) begin
                                ram_rd_en = 1'b1;
                                n_state   = bise_pkg::S_RMW;
                            end else if ((i_in.operation == bise_pkg::OP_ADD) != r_fill) begin
                                n_res_st = bise_pkg::ST_DROPPED;
                            end
                        end
                        bise_pkg::OP_TEST: begin
                            if (in_range) begin
                                ram_rd_en = 1'b1;
                                n_state   = bise_pkg::S_RMW;
                            end else begin
                                n_res_mem = r_fill;
                            end
                        end
                        bise_pkg::OP_NEXT: begin
                            if (in_range) begin
                                ram_rd_en = 1'b1;
                                n_addr    = i_in.element[bise_pkg::WB_LOG +: bise_pkg::WIDX];
                                n_first   = 1'b1;
                                n_state   = bise_pkg::S_SRCH;
                            end else if (r_fill) begin
                                // Start lies at or past capacity, so it is the answer.
                                n_res_mem = 1'b1;
                                n_res_val = i_in.element;
                            end else begin
                                n_res_st = bise_pkg::ST_NONE;
                            end
                        end
                        bise_pkg::OP_COUNT: begin
                            if (!r_fill) begin
                                n_res_val = bise_pkg::VAL_W'(r_count);
                            end
                        end
                        bise_pkg::OP_EMPTY: begin
                            n_res_mem = !r_fill && (r_count == '0);
                        end
                        bise_pkg::OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = bise_pkg::S_CLR;
                        end
                        default: begin
                            // Unused code: plain zero response.
                        end
                    endcase
                end
            end

            bise_pkg::S_RMW: begin
                // Read data for the addressed word is now available.
                ram_wr_addr = r_elem[bise_pkg::WB_LOG +: bise_pkg::WIDX];
                n_res_mem   = (r_op == bise_pkg::OP_TEST) && had;
                if (r_op == bise_pkg::OP_ADD && !had) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data | bit_mask;
                    n_count     = bise_pkg::CNT_W'(r_count + 1'b1);
                end else if (r_op == bise_pkg::OP_DELETE && had) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data & ~bit_mask;
                    n_count     = bise_pkg::CNT_W'(r_count - 1'b1);
                end
                n_state = bise_pkg::S_RESP;
            end

            bise_pkg::S_SRCH: begin
                // One word per cycle; the next read is issued while this one is checked.
                if (scan_word != '0) begin
                    n_res_mem = 1'b1;
                    n_res_val = bise_pkg::VAL_W'({r_addr, low_bit(scan_word)});
                    n_state   = bise_pkg::S_RESP;
                end else if (r_addr == LAST) begin
                    if (r_fill) begin
                        n_res_mem = 1'b1;
                        n_res_val = past_cap;
                    end else begin
                        n_res_st = bise_pkg::ST_NONE;
                    end
                    n_state = bise_pkg::S_RESP;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = bise_pkg::WIDX'(r_addr + 1'b1);
                    n_addr      = bise_pkg::WIDX'(r_addr + 1'b1);
                    n_first     = 1'b0;
                end
            end

            bise_pkg::S_CLR: begin
                // Sweep every word with the fill pattern.
                ram_wr_en   = 1'b1;
                ram_wr_data = r_fill_in ? ALL1 : '0;
                n_addr      = bise_pkg::WIDX'(r_addr + 1'b1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_fill  = r_fill_in;
                    n_count = r_fill_in ? bise_pkg::CNT_W'(bise_pkg::CAP) : '0;
                    n_state = bise_pkg::S_RESP;
                end
            end

            bise_pkg::S_RESP: begin
                // Move the staged response into the output register.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_mem   = r_res_mem;
                    n_out_val   = r_res_val;
                    n_out_unb   = r_fill;
                    n_out_st    = r_res_st;
                    n_state     = bise_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bise_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.is_member = r_out_mem;
    assign o_out.value     = r_out_val;
    assign o_out.unbounded = r_out_unb;
    assign o_out.status    = r_out_st;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// Bitmap integer set engine testbench
// Drives request words into the engine and checks every response word against
// a shadow copy of the bitmap, the trailing fill bit and the member count.
// A short directed run covers the capacity edges, the fill bit and every
// operation. Random traffic follows in three phases with different sender and
// receiver stall rates, and most of it is aimed at a small hot window of elements.
// ============================================================================
module testbench;

    localparam int unsigned CLK_HALF        = 6;
    localparam int unsigned RESET_CYCLES    = 12;
    // The longest quiet stretch is a clearing pass, after reset or on a clear
    // request, or a full search, plus a receiver stall.
    localparam int unsigned WATCHDOG_LIMIT  = 20000;
    localparam int unsigned SETTLE_CYCLES   = 32;
    localparam int unsigned ITEMS_PER_PHASE = 224;
    localparam int unsigned HOT_SPAN        = 3 * bise_pkg::WORD_BITS;
    localparam logic [bise_pkg::OP_W-1:0]   OP_UNUSED = 3'd7;
    localparam logic [bise_pkg::ELEM_W-1:0] ELEM_TOP  = '1;
    localparam logic [bise_pkg::ELEM_W-1:0] ELEM_CAP  = bise_pkg::ELEM_W'(bise_pkg::CAP);
    localparam logic [bise_pkg::ELEM_W-1:0] ELEM_LAST = bise_pkg::ELEM_W'(bise_pkg::CAP - 1);
    localparam logic [bise_pkg::ELEM_W-1:0] ELEM_WORD =
        bise_pkg::ELEM_W'(bise_pkg::WORD_BITS);
    localparam logic [bise_pkg::ELEM_W-1:0] ELEM_ONE  = bise_pkg::ELEM_W'(1);
    localparam bise_pkg::t_word             WORD_ONES = '1;

    // One response word in the order of its channel fields.
    typedef struct packed {
        logic                       is_member;
        logic [bise_pkg::VAL_W-1:0] value;
        logic                       unbounded;
        bise_pkg::t_status          status;
    } t_answer;

    // Shadow of the set state. It works out the answer to each accepted request
    // and keeps the answers that are still due.
    class bitmap_set_shadow;
        bise_pkg::t_word bitmap [bise_pkg::WORDS];
        logic            fill_all;
        int unsigned     members;
        t_answer         due_answers [$];
        int unsigned     op_seen [8];
        int unsigned     checked;
        int unsigned     dropped;
        int unsigned     unfound;
        int unsigned     mismatches;

        function new();
            foreach (bitmap[k]) bitmap[k] = '0;
            foreach (op_seen[k]) op_seen[k] = 0;
            fill_all   = 1'b0;
            members    = 0;
            checked    = 0;
            dropped    = 0;
            unfound    = 0;
            mismatches = 0;
        endfunction

        function void apply_request(logic [bise_pkg::OP_W-1:0] op,
                                    logic [bise_pkg::ELEM_W-1:0] elem, logic fill);
            t_answer         ans;
            int unsigned     w;
            int unsigned     pos;
            int unsigned     idx;
            int unsigned     i;
            bise_pkg::t_word m;
            logic            found;
            ans   = '0;
            w     = elem / bise_pkg::WORD_BITS;
            pos   = elem % bise_pkg::WORD_BITS;
            found = 1'b0;
            op_seen[op]++;
            case (op)
                bise_pkg::OP_ADD, bise_pkg::OP_DELETE: begin
                    if (elem < ELEM_CAP) begin
                        if (op == bise_pkg::OP_ADD && !bitmap[w][pos]) begin
                            bitmap[w][pos] = 1'b1;
                            members++;
                        end else if (op == bise_pkg::OP_DELETE && bitmap[w][pos]) begin
                            bitmap[w][pos] = 1'b0;
                            members--;
                        end
                    end else if ((op == bise_pkg::OP_ADD) != fill_all) begin
                        // Beyond capacity and not settled by the fill bit.
                        ans.status = bise_pkg::ST_DROPPED;
                    end
                end
                bise_pkg::OP_TEST: begin
                    ans.is_member = (elem < ELEM_CAP) ? bitmap[w][pos] : fill_all;
                end
                bise_pkg::OP_NEXT: begin
                    // Scan from the start bit to the end of the bitmap.
                    if (elem < ELEM_CAP) begin
                        for (idx = w; idx < bise_pkg::WORDS && !found; idx++) begin
                            m = bitmap[idx];
                            if (idx == w) m = m & (WORD_ONES << pos);
                            for (i = 0; i < bise_pkg::WORD_BITS && !found; i++) begin
                                if (m[i]) begin
                                    found     = 1'b1;
                                    ans.value = bise_pkg::VAL_W'(idx * bise_pkg::WORD_BITS + i);
                                end
                            end
                        end
                    end
                    if (found) begin
                        ans.is_member = 1'b1;
                    end else if (fill_all) begin
                        // Past capacity every integer is a member.
                        ans.is_member = 1'b1;
                        ans.value     = (elem > ELEM_CAP) ? elem : ELEM_CAP;
                    end else begin
                        ans.status = bise_pkg::ST_NONE;
                    end
                end
                bise_pkg::OP_COUNT: begin
                    if (!fill_all) ans.value = bise_pkg::VAL_W'(members);
                end
                bise_pkg::OP_EMPTY: begin
                    ans.is_member = !fill_all && members == 0;
                end
                bise_pkg::OP_CLEAR: begin
                    foreach (bitmap[k]) bitmap[k] = {bise_pkg::WORD_BITS{fill}};
                    fill_all = fill;
                    members  = fill ? bise_pkg::CAP : 0;
                end
                default: begin
                end
            endcase
            ans.unbounded = fill_all;
            if (ans.status == bise_pkg::ST_DROPPED) dropped++;
            if (ans.status == bise_pkg::ST_NONE) unfound++;
            due_answers.push_back(ans);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_response(t_answer got);
            t_answer want;
            if (due_answers.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response word, expected none, actual %p",
                         $time, got);
                return;
            end
            want = due_answers.pop_front();
            checked++;
            compare_field("is_member", want.is_member, got.is_member);
            compare_field("value", want.value, got.value);
            compare_field("unbounded", want.unbounded, got.unbounded);
            compare_field("status", want.status, got.status);
        endfunction

        function int unsigned outstanding();
            return $unsigned(due_answers.size());
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bise_in_if  req_ch ();
    bise_out_if rsp_ch ();

    bitmap_integer_set_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    bitmap_set_shadow            shadow = new();
    int unsigned                 sender_idle_pct   = 31;
    int unsigned                 receiver_idle_pct = 68;
    int unsigned                 quiet_cycles      = 0;
    logic [bise_pkg::ELEM_W-1:0] hot_base          = '0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Receiver: ready changes at the falling edge and stalls at random.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Every response word is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
            shadow.check_response(t_answer'({rsp_ch.is_member, rsp_ch.value,
                                             rsp_ch.unbounded, rsp_ch.status}));
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one request word, with random gaps first, and returns at the
    // falling edge after it was accepted. Call at a falling edge.
    task automatic send_request(input logic [bise_pkg::OP_W-1:0] op,
                                input logic [bise_pkg::ELEM_W-1:0] elem,
                                input logic fill);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.element   <= elem;
        req_ch.fill      <= fill;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        shadow.apply_request(op, elem, fill);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every due answer has arrived.
    task automatic wait_for_answers();
        req_ch.valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Elements mostly fall into a small hot window so that requests meet each
    // other; the rest probe the capacity edge and the whole 31-bit range.
    function automatic logic [bise_pkg::ELEM_W-1:0] pick_element();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return bise_pkg::ELEM_W'(hot_base + $urandom_range(0, HOT_SPAN - 1));
        if (r < 65) return bise_pkg::ELEM_W'(bise_pkg::CAP - 2 + $urandom_range(0, 3));
        if (r < 80) return bise_pkg::ELEM_W'($urandom_range(0, bise_pkg::CAP - 1));
        if (r < 92) return bise_pkg::ELEM_W'($urandom());
        return bise_pkg::ELEM_W'(ELEM_TOP - $urandom_range(0, 3));
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned r;
        logic [bise_pkg::OP_W-1:0] op;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                r = $urandom_range(0, 2);
                if (r == 0) hot_base = '0;
                else if (r == 1) hot_base = bise_pkg::ELEM_W'(bise_pkg::CAP - HOT_SPAN);
                else hot_base = bise_pkg::ELEM_W'($urandom_range(0, bise_pkg::WORDS - 3)
                                                  * bise_pkg::WORD_BITS);
            end
            r = $urandom_range(0, 99);
            if (r < 26) op = bise_pkg::OP_ADD;
            else if (r < 42) op = bise_pkg::OP_DELETE;
            else if (r < 60) op = bise_pkg::OP_TEST;
            else if (r < 75) op = bise_pkg::OP_NEXT;
            else if (r < 83) op = bise_pkg::OP_COUNT;
            else if (r < 90) op = bise_pkg::OP_EMPTY;
            else if (r < 93) op = bise_pkg::OP_CLEAR;
            else if (r < 94) op = OP_UNUSED;
            else op = bise_pkg::OP_ADD;
            send_request(op, pick_element(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Reset, directed requests, then three phases of random traffic.
    initial begin
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= bise_pkg::OP_ADD;
        req_ch.element   <= '0;
        req_ch.fill      <= 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Edges of the bitmap while the fill bit is clear.
        send_request(bise_pkg::OP_ADD, '0, 1'b0);
        send_request(bise_pkg::OP_ADD, ELEM_LAST, 1'b1);
        send_request(bise_pkg::OP_TEST, '0, 1'b0);
        send_request(bise_pkg::OP_TEST, ELEM_LAST, 1'b0);
        send_request(bise_pkg::OP_TEST, ELEM_CAP, 1'b1);
        send_request(bise_pkg::OP_ADD, ELEM_CAP, 1'b0);
        send_request(bise_pkg::OP_DELETE, ELEM_TOP, 1'b0);
        send_request(bise_pkg::OP_NEXT, ELEM_ONE, 1'b0);
        send_request(bise_pkg::OP_NEXT, ELEM_CAP, 1'b0);
        send_request(bise_pkg::OP_COUNT, '0, 1'b0);
        send_request(bise_pkg::OP_EMPTY, '0, 1'b0);
        send_request(OP_UNUSED, ELEM_TOP, 1'b1);
        send_request(bise_pkg::OP_DELETE, '0, 1'b0);
        send_request(bise_pkg::OP_DELETE, ELEM_LAST, 1'b0);
        send_request(bise_pkg::OP_EMPTY, '0, 1'b1);
        send_request(bise_pkg::OP_NEXT, '0, 1'b0);
        // A full set: the fill bit settles everything past capacity.
        send_request(bise_pkg::OP_CLEAR, ELEM_TOP, 1'b1);
        send_request(bise_pkg::OP_TEST, ELEM_TOP, 1'b0);
        send_request(bise_pkg::OP_ADD, ELEM_TOP, 1'b0);
        send_request(bise_pkg::OP_DELETE, ELEM_CAP, 1'b0);
        send_request(bise_pkg::OP_DELETE, ELEM_WORD, 1'b0);
        send_request(bise_pkg::OP_NEXT, ELEM_WORD, 1'b0);
        send_request(bise_pkg::OP_DELETE, ELEM_LAST, 1'b0);
        send_request(bise_pkg::OP_NEXT, ELEM_LAST, 1'b0);
        send_request(bise_pkg::OP_NEXT, ELEM_TOP, 1'b0);
        send_request(bise_pkg::OP_COUNT, '0, 1'b0);
        send_request(bise_pkg::OP_EMPTY, '0, 1'b0);
        send_request(bise_pkg::OP_CLEAR, '0, 1'b0);
        wait_for_answers();

        run_random(ITEMS_PER_PHASE);
        wait_for_answers();
        sender_idle_pct   = 68;
        receiver_idle_pct = 31;
        run_random(ITEMS_PER_PHASE);
        wait_for_answers();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $write("Requests: %0d add, %0d delete, %0d test, %0d next, ",
               shadow.op_seen[bise_pkg::OP_ADD], shadow.op_seen[bise_pkg::OP_DELETE],
               shadow.op_seen[bise_pkg::OP_TEST], shadow.op_seen[bise_pkg::OP_NEXT]);
        $display("%0d count, %0d empty, %0d clear, %0d unused code.",
                 shadow.op_seen[bise_pkg::OP_COUNT], shadow.op_seen[bise_pkg::OP_EMPTY],
                 shadow.op_seen[bise_pkg::OP_CLEAR], shadow.op_seen[OP_UNUSED]);
        $write("Responses checked: %0d, of them %0d dropped ", shadow.checked, shadow.dropped);
        $display("and %0d searches with no member; %0d mismatches.",
                 shadow.unfound, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
